@@ rtl/fpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLI pixel plotter package
// Beat layouts, command and slot codes, state codes and the address tables
// shared by the plotter core and its sub-blocks.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int IMAGE_BYTES_DEF = 65536;
  localparam int ADDR_BITS       = 16;

  // Command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_PLOT = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Color slot codes
  localparam logic [1:0] SLOT_MC1 = 2'd0;
  localparam logic [1:0] SLOT_BG  = 2'd1;
  localparam logic [1:0] SLOT_FG  = 2'd2;
  localparam logic [1:0] SLOT_MC2 = 2'd3;

  // Bitmap layout
  localparam logic [15:0] BITMAP_BASE_LO = 16'h4000;
  localparam logic [15:0] BITMAP_BASE_HI = 16'h6000;
  localparam logic [15:0] BM_ROW_STRIDE  = 16'd312;

  // Per-line register table layout
  localparam logic [15:0] TABLE_BASE     = 16'h105e;
  localparam logic [15:0] TABLE_ALT_OFS  = 16'd3280;
  localparam logic [15:0] TB_LINE_STRIDE = 16'd17;

  // Attribute layout
  localparam logic [15:0] ATTR_STEP       = 16'h0400;
  localparam logic [15:0] ATTR_ROW_STRIDE = 16'd40;
  localparam logic [15:0] ATTR_BASE_LO [4] = '{16'h2800, 16'h3000, 16'h3800, 16'h9000};
  localparam logic [15:0] ATTR_BASE_HI [4] = '{16'h6800, 16'h7000, 16'h8000, 16'h8800};

  typedef struct packed {
    logic [1:0] command;
    logic [15:0] byte_address;
    logic [7:0] byte_value;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] color_byte;
    logic [1:0] color_slot;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_address;
    logic [7:0] out_data;
    logic last_of_run;
  } out_item_t;

  // Control of the shared address adder
  typedef struct packed {
    logic en;
    logic from_acc;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_BM_A,
    ST_BM_B,
    ST_BM_C,
    ST_BM_RD,
    ST_BM_WR,
    ST_TB_A,
    ST_TB_WR,
    ST_AT_A,
    ST_AT_B,
    ST_AT_C,
    ST_AT_RDC,
    ST_AT_RDL,
    ST_AT_WRC,
    ST_AT_WRL
  } state_t;

  // Rows that take the upper bitmap and attribute banks
  function automatic logic hi_region(input logic [7:0] x, input logic [7:0] y);
    return (y >= 8'd192) && ((y < 8'd200) || ((y < 8'd208) && (x < 8'd96)));
  endfunction

  // Constant part of the per-line table address
  function automatic logic [15:0] table_seed(input logic [7:0] y, input logic [1:0] slot);
    logic [7:0] yy;
    logic [15:0] z;
    logic [15:0] seed;
    yy = {y[7:1], 1'b0};
    z = (slot == SLOT_MC2) ? 16'd5 : 16'd0;
    if (yy == 8'd192) begin
      if (y[0]) begin
        seed = TABLE_BASE + TABLE_ALT_OFS + z;
      end else begin
        seed = TABLE_BASE - 16'd4 + ((slot == SLOT_MC2) ? 16'd2 : 16'd0);
      end
    end else begin
      seed = TABLE_BASE + (y[0] ? 16'd14 : 16'd0) + ((yy > 8'd192) ? 16'd2 : 16'd0) + z;
    end
    return seed;
  endfunction

  // Attribute bank base for a pixel
  function automatic logic [15:0] attr_seed(input logic [7:0] x, input logic [7:0] y);
    logic [1:0] sel;
    logic [15:0] ab;
    sel = y[2:1];
    if (y < 8'd192) begin
      ab = ATTR_BASE_LO[sel];
    end else if (hi_region(x, y)) begin
      ab = ATTR_BASE_HI[sel];
    end else begin
      ab = ATTR_BASE_HI[sel] - ATTR_STEP;
    end
    return ab;
  endfunction

  // Replace the 2-bit pixel picked by the low column bits
  function automatic logic [7:0] pixel_merge(input logic [7:0] v, input logic [1:0] xl,
                                              input logic [1:0] slot);
    logic [7:0] r;
    r = v;
    case (xl)
      2'd0: r[7:6] = slot;
      2'd1: r[5:4] = slot;
      2'd2: r[3:2] = slot;
      2'd3: r[1:0] = slot;
      default: r = v;
    endcase
    return r;
  endfunction

  // Merge the hue nibble into the color byte
  function automatic logic [7:0] color_merge(input logic [7:0] v, input logic [7:0] c,
                                              input logic [1:0] slot);
    return (slot == SLOT_FG) ? {v[7:4], c[3:0]} : {c[3:0], v[3:0]};
  endfunction

  // Merge the luminance nibble into the luminance byte
  function automatic logic [7:0] luma_merge(input logic [7:0] v, input logic [7:0] c,
                                             input logic [1:0] slot);
    return (slot == SLOT_FG) ? {c[7:4], v[3:0]} : {v[7:4], c[7:4]};
  endfunction

endpackage

@@ rtl/fpp_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLI pixel plotter stream interface
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface fpp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/fpp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLI pixel plotter RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fpp_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLI pixel plotter address adder
// Shared accumulator that builds every plot address one term per cycle while enabled.
// ----------------------------------------------------------------------------
module fpp_alu (
  input  logic clk,
  input  fpp_pkg::alu_ctl_t ctl,
  input  logic [fpp_pkg::ADDR_BITS-1:0] seed,
  input  logic [fpp_pkg::ADDR_BITS-1:0] operand,
  output logic [fpp_pkg::ADDR_BITS-1:0] acc
);

  logic [fpp_pkg::ADDR_BITS-1:0] base_term;

  // Start from a fresh seed or keep accumulating
  assign base_term = ctl.from_acc ? acc : seed;

  // Add one term, wrapping to the address width
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base_term + operand;
    end
  end

endmodule

@@ rtl/fli_pixel_plotter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLI pixel plotter core
// Byte image of a multicolor FLI picture with load, read and pixel plot
// commands; every memory write and every read command leaves as one result beat.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  request  | in  | valid / ready | command, byte address/value, pixel, color
//  result   | out | valid / ready | out_address, out_data, last_of_run
//
//  A plot with slot 0 or 3 writes a bitmap and a table byte, a plot with
//  slot 1 or 2 a bitmap and two attribute bytes; the single shared address
//  adder builds every plot address. Request ready is high only when idle.
//  A result waits in the output register; a new result stalls the sequencer
//  until that register is free. Reset clears the sequencer and the output
//  valid; image contents are undefined until loaded.
// ----------------------------------------------------------------------------
module fli_pixel_plotter_core #(
  parameter int IMAGE_BYTES = fpp_pkg::IMAGE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  fpp_stream_if.sink request,
  fpp_stream_if.source result
);

  localparam int AW = $clog2(IMAGE_BYTES);

  fpp_pkg::state_t state, state_next;
  fpp_pkg::in_item_t item;
  fpp_pkg::out_item_t out_item;
  fpp_pkg::out_item_t emit_item;
  logic out_valid;
  logic emit;
  logic can_emit;

  fpp_pkg::alu_ctl_t alu_ctl;
  logic [fpp_pkg::ADDR_BITS-1:0] seed;
  logic [fpp_pkg::ADDR_BITS-1:0] operand;
  logic [fpp_pkg::ADDR_BITS-1:0] acc;
  logic [fpp_pkg::ADDR_BITS-1:0] la;
  logic [7:0] cc;

  logic ram_we;
  logic ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;

  logic accept;

  assign accept = request.valid && request.ready;
  assign can_emit = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.payload = out_item;

  fpp_alu u_alu (
    .clk     (clk),
    .ctl     (alu_ctl),
    .seed    (seed),
    .operand (operand),
    .acc     (acc)
  );

  fpp_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: hold until taken, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
  end

  // Capture the request beat and intermediate plot values
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= request.payload;
    end
    if (state == fpp_pkg::ST_AT_C) begin
      la <= acc;
    end
    if (state == fpp_pkg::ST_AT_RDL) begin
      cc <= fpp_pkg::color_merge(ram_rdata, item.color_byte, item.color_slot);
    end
  end

  // Sequencer: next state, adder control, memory access and emit
  always_comb begin
    state_next = state;
    request.ready = 1'b0;
    alu_ctl = '0;
    seed = '0;
    operand = '0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = acc[AW-1:0];
    ram_raddr = acc[AW-1:0];
    ram_wdata = '0;
    emit = 1'b0;
    emit_item = '0;
    case (state)
      fpp_pkg::ST_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) begin
          case (request.payload.command)
            fpp_pkg::CMD_LOAD: state_next = fpp_pkg::ST_LOAD;
            fpp_pkg::CMD_PLOT: state_next = fpp_pkg::ST_BM_A;
            fpp_pkg::CMD_READ: state_next = fpp_pkg::ST_RD_ISSUE;
            default: state_next = fpp_pkg::ST_IDLE;
          endcase
        end
      end
      fpp_pkg::ST_LOAD: begin
        ram_waddr = item.byte_address[AW-1:0];
        ram_wdata = item.byte_value;
        emit_item = '{out_address: item.byte_address, out_data: item.byte_value,
                      last_of_run: 1'b1};
        if (can_emit) begin
          ram_we = 1'b1;
          emit = 1'b1;
          state_next = fpp_pkg::ST_IDLE;
        end
      end
      fpp_pkg::ST_RD_ISSUE: begin
        ram_re = 1'b1;
        ram_raddr = item.byte_address[AW-1:0];
        state_next = fpp_pkg::ST_RD_DATA;
      end
      fpp_pkg::ST_RD_DATA: begin
        emit_item = '{out_address: item.byte_address, out_data: ram_rdata,
                      last_of_run: 1'b1};
        if (can_emit) begin
          emit = 1'b1;
          state_next = fpp_pkg::ST_IDLE;
        end
      end
      // Bitmap address: base + y, then row stride, then column byte
      fpp_pkg::ST_BM_A: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b0};
        seed = fpp_pkg::hi_region(item.pixel_x, item.pixel_y) ?
               fpp_pkg::BITMAP_BASE_HI : fpp_pkg::BITMAP_BASE_LO;
        operand = 16'(item.pixel_y);
        state_next = fpp_pkg::ST_BM_B;
      end
      fpp_pkg::ST_BM_B: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b1};
        operand = 16'(item.pixel_y[7:3]) * fpp_pkg::BM_ROW_STRIDE;
        state_next = fpp_pkg::ST_BM_C;
      end
      fpp_pkg::ST_BM_C: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b1};
        operand = 16'({item.pixel_x[7:2], 3'b000});
        state_next = fpp_pkg::ST_BM_RD;
      end
      fpp_pkg::ST_BM_RD: begin
        ram_re = 1'b1;
        state_next = fpp_pkg::ST_BM_WR;
      end
      fpp_pkg::ST_BM_WR: begin
        ram_wdata = fpp_pkg::pixel_merge(ram_rdata, item.pixel_x[1:0], item.color_slot);
        emit_item = '{out_address: acc, out_data: ram_wdata, last_of_run: 1'b0};
        if (can_emit) begin
          ram_we = 1'b1;
          emit = 1'b1;
          if (item.color_slot == fpp_pkg::SLOT_MC1 || item.color_slot == fpp_pkg::SLOT_MC2) begin
            state_next = fpp_pkg::ST_TB_A;
          end else begin
            state_next = fpp_pkg::ST_AT_A;
          end
        end
      end
      // Per-line table address: fixed part plus line stride
      fpp_pkg::ST_TB_A: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b0};
        seed = fpp_pkg::table_seed(item.pixel_y, item.color_slot);
        if ({item.pixel_y[7:1], 1'b0} != 8'd192) begin
          operand = 16'({item.pixel_y[7:1], 1'b0}) * fpp_pkg::TB_LINE_STRIDE;
        end
        state_next = fpp_pkg::ST_TB_WR;
      end
      fpp_pkg::ST_TB_WR: begin
        ram_wdata = item.color_byte;
        emit_item = '{out_address: acc, out_data: item.color_byte, last_of_run: 1'b1};
        if (can_emit) begin
          ram_we = 1'b1;
          emit = 1'b1;
          state_next = fpp_pkg::ST_IDLE;
        end
      end
      // Attribute addresses: luminance byte, then color byte one bank up
      fpp_pkg::ST_AT_A: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b0};
        seed = fpp_pkg::attr_seed(item.pixel_x, item.pixel_y);
        operand = 16'(item.pixel_y[7:3]) * fpp_pkg::ATTR_ROW_STRIDE;
        state_next = fpp_pkg::ST_AT_B;
      end
      fpp_pkg::ST_AT_B: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b1};
        operand = 16'(item.pixel_x[7:2]);
        state_next = fpp_pkg::ST_AT_C;
      end
      fpp_pkg::ST_AT_C: begin
        alu_ctl = '{en: 1'b1, from_acc: 1'b1};
        operand = fpp_pkg::ATTR_STEP;
        state_next = fpp_pkg::ST_AT_RDC;
      end
      fpp_pkg::ST_AT_RDC: begin
        ram_re = 1'b1;
        state_next = fpp_pkg::ST_AT_RDL;
      end
      fpp_pkg::ST_AT_RDL: begin
        ram_re = 1'b1;
        ram_raddr = la[AW-1:0];
        state_next = fpp_pkg::ST_AT_WRC;
      end
      fpp_pkg::ST_AT_WRC: begin
        ram_wdata = cc;
        emit_item = '{out_address: acc, out_data: cc, last_of_run: 1'b0};
        if (can_emit) begin
          ram_we = 1'b1;
          emit = 1'b1;
          state_next = fpp_pkg::ST_AT_WRL;
        end
      end
      fpp_pkg::ST_AT_WRL: begin
        ram_waddr = la[AW-1:0];
        ram_wdata = fpp_pkg::luma_merge(ram_rdata, item.color_byte, item.color_slot);
        emit_item = '{out_address: la, out_data: ram_wdata, last_of_run: 1'b1};
        if (can_emit) begin
          ram_we = 1'b1;
          emit = 1'b1;
          state_next = fpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sim/tb_fli_pixel_plotter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLI pixel plotter core testbench
// Sends load, read and plot commands through the request channel and checks
// every memory access beat on the result channel against a local image copy.
// Bytes are always loaded before any command reads them. The sender idles in
// bursts and the receiver stalls on a random pattern.
// ----------------------------------------------------------------------------
module tb_fli_pixel_plotter_core;
  import fpp_pkg::*;

  // Code that the core ignores
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_COMMANDS = 430;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpp_stream_if #(.T(in_item_t)) req_if ();
  fpp_stream_if #(.T(out_item_t)) result_if ();

  fli_pixel_plotter_core i_dut (
    .clk(clk),
    .rst(rst),
    .request(req_if),
    .result(result_if)
  );

  // Commands waiting to go out, expected accesses, local image copy
  in_item_t command_q[$];
  out_item_t pending_accesses[$];
  logic [7:0] image_copy [IMAGE_BYTES_DEF];

  // Bytes known to be written at generation time
  bit written [IMAGE_BYTES_DEF];
  logic [15:0] written_list[$];

  int unsigned n_accepted = 0;
  int unsigned n_commands = 0;
  int unsigned fail_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [31:0] stall_pattern = '1;
  logic [4:0] stall_phase = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bitmap, table and attribute addresses of one pixel
  function automatic void locate_pixel(input logic [7:0] x, input logic [7:0] y,
                                       input logic [1:0] slot, output logic [15:0] bm_a,
                                       output logic [15:0] tb_a, output logic [15:0] col_a,
                                       output logic [15:0] lum_a);
    int unsigned xi, yi, ye, z, t, ab, p;
    logic upper;
    xi = x;
    yi = y;
    upper = (yi >= 192) && ((yi < 200) || ((yi < 208) && (xi < 96)));
    bm_a = 16'((upper ? BITMAP_BASE_HI : BITMAP_BASE_LO) + 312 * (yi >> 3)
               + ((xi & 32'hfc) << 1) + yi);
    z = (slot == SLOT_MC2) ? 5 : 0;
    if (!y[0]) begin
      if (yi < 192) t = TABLE_BASE + yi * 17 + z;
      else if (yi == 192) t = TABLE_BASE - 4 + ((slot == SLOT_MC2) ? 2 : 0);
      else t = TABLE_BASE + 2 + yi * 17 + z;
    end else begin
      ye = yi - 1;
      if (ye < 192) t = TABLE_BASE + 14 + ye * 17 + z;
      else if (ye == 192) t = TABLE_BASE + 3280 + z;
      else t = TABLE_BASE + 16 + ye * 17 + z;
    end
    tb_a = 16'(t);
    p = (yi >> 3) * 40 + (xi >> 2);
    if (yi < 192) ab = ATTR_BASE_LO[y[2:1]];
    else if (upper) ab = ATTR_BASE_HI[y[2:1]];
    else ab = ATTR_BASE_HI[y[2:1]] - 32'h400;
    col_a = 16'(ab + p + 32'h400);
    lum_a = 16'(ab + p);
  endfunction

  // Write one byte of the image copy and expect its beat
  task automatic store_byte(input logic [15:0] a, input logic [7:0] v, input logic last);
    out_item_t beat;
    image_copy[a] = v;
    beat.out_address = a;
    beat.out_data = v;
    beat.last_of_run = last;
    pending_accesses.push_back(beat);
  endtask

  // Apply one accepted command to the image copy
  task automatic replay_command(input in_item_t it);
    logic [15:0] bm_a, tb_a, col_a, lum_a;
    logic [7:0] v, c;
    out_item_t beat;
    int unsigned sh;
    c = it.color_byte;
    case (it.command)
      CMD_LOAD: begin
        store_byte(it.byte_address, it.byte_value, 1'b1);
      end
      CMD_READ: begin
        beat.out_address = it.byte_address;
        beat.out_data = image_copy[it.byte_address];
        beat.last_of_run = 1'b1;
        pending_accesses.push_back(beat);
      end
      CMD_PLOT: begin
        locate_pixel(it.pixel_x, it.pixel_y, it.color_slot, bm_a, tb_a, col_a, lum_a);
        sh = 6 - 2 * it.pixel_x[1:0];
        v = image_copy[bm_a];
        v = (v & ~(8'd3 << sh)) | ({6'd0, it.color_slot} << sh);
        store_byte(bm_a, v, 1'b0);
        if (it.color_slot == SLOT_MC1 || it.color_slot == SLOT_MC2) begin
          store_byte(tb_a, c, 1'b1);
        end else begin
          v = image_copy[col_a];
          v = (it.color_slot == SLOT_FG) ? {v[7:4], c[3:0]} : {c[3:0], v[3:0]};
          store_byte(col_a, v, 1'b0);
          // read after the color write; the two bytes lie one attribute bank apart
          v = image_copy[lum_a];
          v = (it.color_slot == SLOT_FG) ? {c[7:4], v[3:0]} : {v[7:4], c[7:4]};
          store_byte(lum_a, v, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic in_item_t random_item(input logic [1:0] cmd);
    in_item_t it;
    it.command = cmd;
    it.byte_address = 16'($urandom);
    it.byte_value = 8'($urandom);
    it.pixel_x = 8'($urandom);
    it.pixel_y = 8'($urandom);
    it.color_byte = 8'($urandom);
    it.color_slot = 2'($urandom);
    return it;
  endfunction

  task automatic mark_written(input logic [15:0] a);
    if (!written[a]) begin
      written[a] = 1'b1;
      written_list.push_back(a);
    end
  endtask

  task automatic queue_load(input logic [15:0] a, input logic [7:0] v);
    in_item_t it;
    it = random_item(CMD_LOAD);
    it.byte_address = a;
    it.byte_value = v;
    command_q.push_back(it);
    n_commands++;
    mark_written(a);
  endtask

  task automatic ensure_written(input logic [15:0] a);
    if (!written[a]) queue_load(a, 8'($urandom));
  endtask

  task automatic queue_read(input logic [15:0] a);
    in_item_t it;
    ensure_written(a);
    it = random_item(CMD_READ);
    it.byte_address = a;
    command_q.push_back(it);
    n_commands++;
  endtask

  // Load every byte the plot reads, then the plot itself
  task automatic queue_plot(input logic [7:0] x, input logic [7:0] y, input logic [7:0] c,
                            input logic [1:0] slot);
    in_item_t it;
    logic [15:0] bm_a, tb_a, col_a, lum_a;
    locate_pixel(x, y, slot, bm_a, tb_a, col_a, lum_a);
    ensure_written(bm_a);
    if (slot == SLOT_BG || slot == SLOT_FG) begin
      ensure_written(col_a);
      ensure_written(lum_a);
    end else begin
      mark_written(tb_a);
    end
    it = random_item(CMD_PLOT);
    it.pixel_x = x;
    it.pixel_y = y;
    it.color_byte = c;
    it.color_slot = slot;
    command_q.push_back(it);
    n_commands++;
  endtask

  task automatic queue_ignored();
    command_q.push_back(random_item(CMD_NONE));
    n_commands++;
  endtask

  // Request driver: bursts with random gaps, hold the beat until taken
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        replay_command(req_if.payload);
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0 || command_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid <= 1'b1;
          req_if.payload <= command_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end
        end
      end
    end
  end

  // Result receiver: stall on a random pattern, redrawn each time the phase counter wraps
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (stall_phase == 5'd0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = $urandom;
          2: stall_pattern = $urandom | $urandom;
          default: stall_pattern = $urandom & $urandom & $urandom;
        endcase
      end
      result_if.ready <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 5'd1;
    end
  end

  // Result monitor: compare each beat with the oldest expected access
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (pending_accesses.size() == 0) begin
        if (fail_count < 10) begin
          $display("%0t: unexpected beat addr %h data %h last %b", $realtime,
                   got.out_address, got.out_data, got.last_of_run);
        end
        fail_count++;
      end else begin
        want = pending_accesses.pop_front();
        if (got.out_address !== want.out_address || got.out_data !== want.out_data
            || got.last_of_run !== want.last_of_run) begin
          if (fail_count < 10) begin
            $display("%0t: beat addr %h data %h last %b, expected addr %h data %h last %b",
                     $realtime, got.out_address, got.out_data, got.last_of_run,
                     want.out_address, want.out_data, want.last_of_run);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned n_ignored;
    int unsigned pick;
    logic [7:0] px, py;
    logic [7:0] last_x, last_y;
    n_ignored = 0;
    last_x = 8'd0;
    last_y = 8'd0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    result_if.ready = 1'b0;

    // Directed: address extremes, ignored code, plot corner cases
    queue_load(16'h0000, 8'h00);
    queue_load(16'hffff, 8'hff);
    queue_read(16'hffff);
    queue_read(16'h0000);
    queue_ignored();
    n_ignored++;
    queue_plot(8'd0, 8'd0, 8'h00, SLOT_MC1);
    queue_plot(8'd159, 8'd255, 8'hff, SLOT_MC2);
    // column beyond the picture
    queue_plot(8'd255, 8'd255, 8'ha5, SLOT_FG);
    // first border line, the odd line after it and the next even line
    queue_plot(8'd1, 8'd192, 8'h3c, SLOT_MC2);
    queue_plot(8'd2, 8'd193, 8'hc3, SLOT_MC1);
    queue_plot(8'd3, 8'd194, 8'h5a, SLOT_MC2);
    // upper bank edges and the shifted attribute bank
    queue_plot(8'd100, 8'd199, 8'h71, SLOT_BG);
    queue_plot(8'd95, 8'd207, 8'h8e, SLOT_FG);
    queue_plot(8'd96, 8'd207, 8'h19, SLOT_BG);
    // same pixel twice, both attribute merges
    queue_plot(8'd40, 8'd191, 8'hf0, SLOT_FG);
    queue_plot(8'd40, 8'd191, 8'h0f, SLOT_BG);

    // Random: mostly plots, with loads, reads and a few ignored codes
    while (command_q.size() - n_ignored < RANDOM_COMMANDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 4) == 0) begin
          px = last_x;
          py = last_y;
        end else begin
          px = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(160, 255))
                                           : 8'($urandom_range(0, 159));
          py = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(184, 215))
                                           : 8'($urandom_range(0, 255));
        end
        queue_plot(px, py, 8'($urandom), 2'($urandom));
        last_x = px;
        last_y = py;
      end else if (pick < 75) begin
        queue_read(written_list[$urandom_range(0, written_list.size() - 1)]);
      end else if (pick < 96) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_load(16'($urandom), 8'($urandom));
        end else begin
          queue_load(written_list[$urandom_range(0, written_list.size() - 1)], 8'($urandom));
        end
      end else begin
        queue_ignored();
        n_ignored++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain: every command taken, every access seen, then a short tail
    while (n_accepted != n_commands) @(posedge clk);
    while (pending_accesses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("fli_pixel_plotter_core: match");
    end else begin
      $display("fli_pixel_plotter_core: mismatch");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("fli_pixel_plotter_core: mismatch");
    $finish;
  end

endmodule
